FILE: hdl/assert_macros.svh
// Concurrent assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: hdl/arfe_pkg.sv
// Shared types and constants of the average reduced frequency engine.
package arfe_pkg;

  localparam int unsigned IN_ID_W  = 16;
  localparam int unsigned IN_POS_W = 32;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned INT_BITS = 32;

  localparam logic [SIZE_W-1:0] CORPUS_RESET = 32'd1;

  localparam logic CMD_HIT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic clr_wr;    // clearing pass: zero one table entry
    logic accept;    // capture the input transfer
    logic load;      // latch table entry, form the gap
    logic mul;       // gap times frequency
    logic chk;       // pick the contribution or start the divider
    logic div_step;  // one quotient bit
    logic commit;    // write the entry back, present a read-out result
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

FILE: hdl/arfe_ram.sv
// Generic single write port, single read port RAM with registered read.
module arfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/arfe_ctrl.sv
// Sequencing state machine of the average reduced frequency engine.
module arfe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  arfe_pkg::dp_status_t status_i,
  output arfe_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = status_i.need_div ? S_DIV : S_ADD;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: hdl/arfe_datapath.sv
// Table, multiplier, restoring divider and saturating accumulator.
module arfe_datapath #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  arfe_pkg::ctrl_cmd_t                     cmd_i,
  output arfe_pkg::dp_status_t                    status_o,
  input  logic                                    cfg_we_i,
  input  logic [arfe_pkg::SIZE_W-1:0]             cfg_wdata_i,
  input  logic                                    command_i,
  input  logic [arfe_pkg::IN_POS_W-1:0]           position_i,
  input  logic [arfe_pkg::IN_ID_W-1:0]            token_id_i,
  input  logic [arfe_pkg::FREQ_W-1:0]             token_freq_i,
  output logic                                    result_strobe_o,
  output logic [arfe_pkg::IN_ID_W-1:0]            result_id_o,
  output logic                                    occurred_o,
  output logic [arfe_pkg::INT_BITS+FRAC_BITS-1:0] arf_value_o
);

  localparam int unsigned SW    = arfe_pkg::SIZE_W;
  localparam int unsigned FW    = arfe_pkg::FREQ_W;
  localparam int unsigned SUMW  = arfe_pkg::INT_BITS + FRAC_BITS;
  localparam int unsigned GW    = ((POS_BITS > SW) ? POS_BITS : SW) + 1;
  localparam int unsigned PW    = SW + FW;
  localparam int unsigned CW    = $clog2(FRAC_BITS + 1);
  localparam int unsigned DEPTH = 1 << ID_BITS;
  localparam int unsigned IDW   = arfe_pkg::IN_ID_W;

  localparam logic [SUMW-1:0] ONE_FIX = SUMW'(1) << FRAC_BITS;

  typedef struct packed {
    logic                seen;
    logic [POS_BITS-1:0] first;
    logic [POS_BITS-1:0] prev;
    logic [SUMW-1:0]     sum;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  logic [ID_BITS+IDW-1:0]                 id_ext;
  logic [POS_BITS+arfe_pkg::IN_POS_W-1:0] pos_ext;
  logic [ID_BITS-1:0]                     rd_idx;

  logic                 cmd_q;
  logic [POS_BITS-1:0]  pos_q;
  logic [ID_BITS-1:0]   idx_q;
  logic [FW-1:0]        freq_q;
  logic [SW-1:0]        size_q;
  entry_t               ent_q;
  logic [GW-1:0]        gap_q, gap_d;
  logic [PW-1:0]        prod_q;
  logic                 big_q, fz_q;
  logic [SW-1:0]        rem_q, rem_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic [CW-1:0]        cnt_q;
  logic [SUMW-1:0]      amt_q;
  logic [ID_BITS-1:0]   clr_q;

  logic                 stb_q;
  logic [IDW-1:0]       rid_q;
  logic                 occ_q;
  logic [SUMW-1:0]      val_q;

  entry_t               rd_ent, wr_ent;
  logic [EW-1:0]        rd_data;
  logic                 ram_we;
  logic [ID_BITS-1:0]   ram_waddr;
  logic [GW-1:0]        cyc_end, prev_ext, pos_gext, size_gext;
  logic [SW:0]          rem2;
  logic                 rem_ge;
  logic [SUMW:0]        sum_ext;
  logic [SUMW-1:0]      sum_sat;
  logic                 prod_big;
  logic [ID_BITS+IDW-1:0] rid_ext;

  assign id_ext  = {{ID_BITS{1'b0}}, token_id_i};
  assign pos_ext = {{POS_BITS{1'b0}}, position_i};
  assign rd_idx  = id_ext[ID_BITS-1:0];

  arfe_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_ent),
    .raddr_i (rd_idx),
    .rdata_o (rd_data)
  );

  assign rd_ent = entry_t'(rd_data);

  // Gap from the entry as it comes out of the table.
  always_comb begin
    prev_ext  = GW'(rd_ent.prev);
    pos_gext  = GW'(pos_q);
    size_gext = GW'(size_q);
    cyc_end   = GW'(rd_ent.first) + size_gext;
    if (cmd_q == arfe_pkg::CMD_HIT) begin
      gap_d = (pos_gext > prev_ext) ? (pos_gext - prev_ext) : '0;
    end else begin
      gap_d = (cyc_end > prev_ext) ? (cyc_end - prev_ext) : '0;
    end
  end

  assign prod_big = (prod_q >= PW'(size_q));

  // One restoring step; the remainder stays below the corpus size.
  always_comb begin
    rem2   = {rem_q, 1'b0};
    rem_ge = (rem2 >= {1'b0, size_q});
    rem_d  = rem_ge ? SW'(rem2 - {1'b0, size_q}) : rem2[SW-1:0];
    quo_d  = {quo_q[FRAC_BITS-2:0], rem_ge};
  end

  always_comb begin
    sum_ext = {1'b0, ent_q.sum} + {1'b0, amt_q};
    sum_sat = sum_ext[SUMW] ? {SUMW{1'b1}} : sum_ext[SUMW-1:0];
  end

  always_comb begin
    wr_ent = '0;
    if (cmd_i.commit && (cmd_q == arfe_pkg::CMD_HIT)) begin
      wr_ent.seen = 1'b1;
      if (ent_q.seen) begin
        wr_ent.first = ent_q.first;
        wr_ent.prev  = pos_q;
        wr_ent.sum   = sum_sat;
      end else begin
        wr_ent.first = pos_q;
        wr_ent.prev  = pos_q;
      end
    end
  end

  assign ram_we    = cmd_i.clr_wr | cmd_i.commit;
  assign ram_waddr = cmd_i.clr_wr ? clr_q : idx_q;

  assign status_o.clr_last = &clr_q;
  assign status_o.need_div = !fz_q && !big_q && !prod_big;
  assign status_o.div_last = (cnt_q == CW'(1));

  assign rid_ext = {{IDW{1'b0}}, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= arfe_pkg::CORPUS_RESET;
      clr_q  <= '0;
      stb_q  <= 1'b0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (cmd_i.clr_wr) clr_q <= clr_q + ID_BITS'(1);
      stb_q <= cmd_i.commit && (cmd_q == arfe_pkg::CMD_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= command_i;
      pos_q  <= pos_ext[POS_BITS-1:0];
      idx_q  <= rd_idx;
      freq_q <= token_freq_i;
    end
    if (cmd_i.load) begin
      ent_q <= rd_ent;
      gap_q <= gap_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(gap_q[SW-1:0]) * PW'(freq_q);
      big_q  <= (gap_q >= GW'(size_q));
      fz_q   <= (freq_q == '0);
    end
    if (cmd_i.chk) begin
      amt_q <= fz_q ? '0 : ONE_FIX;
      rem_q <= prod_q[SW-1:0];
      quo_q <= '0;
      cnt_q <= CW'(FRAC_BITS);
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) amt_q <= SUMW'(quo_d);
    end
    if (cmd_i.commit) begin
      rid_q <= rid_ext[IDW-1:0];
      occ_q <= ent_q.seen;
      val_q <= ent_q.seen ? sum_sat : '0;
    end
  end

  assign result_strobe_o = stb_q;
  assign result_id_o     = rid_q;
  assign occurred_o      = occ_q;
  assign arf_value_o     = val_q;

endmodule

FILE: hdl/average_reduced_frequency_engine_top.sv
// Top level of the average reduced frequency engine.
// One command is taken per transfer (start_i high while busy_o is low) and is
// worked through one at a time by a controller and a datapath around a single
// table RAM of 2^ID_BITS entries. A hit passes the load, multiply, check and
// commit states before the next transfer when its contribution is zero or a
// full 1.0; when the fraction has to be formed, the restoring divider runs
// between check and commit and yields one quotient bit per cycle. A read-out
// passes through the same states and puts its result on the result ports for
// exactly one cycle, marked by result_strobe_o, in the first cycle in which
// busy_o is low again; the receiver has to take it then. After reset the table
// is zeroed by a clearing pass over all 2^ID_BITS entries, during which busy_o
// is high; write the corpus size only while busy_o is low.
`include "assert_macros.svh"

module average_reduced_frequency_engine_top #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [arfe_pkg::SIZE_W-1:0]             cfg_wdata_i,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic                                    command_i,
  input  logic [arfe_pkg::IN_POS_W-1:0]           position_i,
  input  logic [arfe_pkg::IN_ID_W-1:0]            token_id_i,
  input  logic [arfe_pkg::FREQ_W-1:0]             token_freq_i,
  output logic                                    result_strobe_o,
  output logic [arfe_pkg::IN_ID_W-1:0]            result_id_o,
  output logic                                    occurred_o,
  output logic [arfe_pkg::INT_BITS+FRAC_BITS-1:0] arf_value_o
);

  arfe_pkg::ctrl_cmd_t  cmd;
  arfe_pkg::dp_status_t status;

  arfe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  arfe_datapath #(
    .ID_BITS   (ID_BITS),
    .POS_BITS  (POS_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .position_i      (position_i),
    .token_id_i      (token_id_i),
    .token_freq_i    (token_freq_i),
    .result_strobe_o (result_strobe_o),
    .result_id_o     (result_id_o),
    .occurred_o      (occurred_o),
    .arf_value_o     (arf_value_o)
  );

  // A transfer always occupies the block for at least the next cycle.
  `ASSERT_CLK(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "transfer not held busy")
  // Results appear only once the block is free again.
  `ASSERT_NEVER(a_strobe_busy, clk_i, rst_ni, result_strobe_o && busy_o, "result while busy")
  // Each result is presented for a single cycle.
  `ASSERT_CLK(a_strobe_once, clk_i, rst_ni, result_strobe_o |=> !result_strobe_o, "result repeated")
  // The table is never written by the clearing pass and a command together.
  `ASSERT_NEVER(a_wr_excl, clk_i, rst_ni, cmd.clr_wr && (cmd.commit || cmd.accept), "clear overlap")

endmodule

FILE: tb/arf_readout_monitor.sv
// Checker for the ARF engine: mirrors the per-id table, predicts read-outs, compares results.
`timescale 1ns / 100ps

module arf_readout_monitor #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [arfe_pkg::SIZE_W-1:0]             cfg_wdata_i,
  input  logic                                    start_i,
  input  logic                                    busy_i,
  input  logic                                    command_i,
  input  logic [arfe_pkg::IN_POS_W-1:0]           position_i,
  input  logic [arfe_pkg::IN_ID_W-1:0]            token_id_i,
  input  logic [arfe_pkg::FREQ_W-1:0]             token_freq_i,
  input  logic                                    result_strobe_i,
  input  logic [arfe_pkg::IN_ID_W-1:0]            result_id_i,
  input  logic                                    occurred_i,
  input  logic [arfe_pkg::INT_BITS+FRAC_BITS-1:0] arf_value_i,
  output int unsigned                             outstanding_o,
  output int unsigned                             mismatches_o
);

  localparam int unsigned SUM_W    = arfe_pkg::INT_BITS + FRAC_BITS;
  localparam int unsigned ID_COUNT = 1 << ID_BITS;
  localparam logic [63:0] ONE_FIX  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] SUM_MAX  = (64'd1 << SUM_W) - 64'd1;

  typedef struct packed {
    logic [arfe_pkg::IN_ID_W-1:0] id;
    logic                         occurred;
    logic [SUM_W-1:0]             value;
  } readout_t;

  logic [arfe_pkg::SIZE_W-1:0] corpus_size;
  bit                          id_seen   [ID_COUNT];
  bit   [31:0]                 first_pos [ID_COUNT];
  bit   [31:0]                 prev_hit_pos [ID_COUNT];
  bit   [SUM_W-1:0]            arf_sum   [ID_COUNT];
  readout_t                    due_readouts [$];
  int unsigned                 mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // min(gap * freq / size, 1.0) in fixed point, truncated
  function automatic logic [63:0] reduced_step(input logic [32:0] gap, input logic [31:0] freq);
    logic [63:0] prod;
    if (freq == '0) return '0;
    if (gap >= {1'b0, corpus_size}) return ONE_FIX;
    prod = 64'(gap) * 64'(freq);
    if (prod >= 64'(corpus_size)) return ONE_FIX;
    return (prod << FRAC_BITS) / 64'(corpus_size);
  endfunction

  function automatic void add_to_sum(input int unsigned idx, input logic [63:0] amount);
    logic [63:0] total;
    total = 64'(arf_sum[idx]) + amount;
    arf_sum[idx] = (total > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : total[SUM_W-1:0];
  endfunction

  function automatic void apply_command(input logic cmd, input logic [31:0] pos,
                                        input logic [15:0] id, input logic [31:0] freq);
    int unsigned idx;
    logic [32:0] gap;
    logic [32:0] wrap_end;
    readout_t    due;
    idx = id % ID_COUNT;
    if (cmd == arfe_pkg::CMD_HIT) begin
      if (!id_seen[idx]) begin
        id_seen[idx]      = 1'b1;
        first_pos[idx]    = pos;
        prev_hit_pos[idx] = pos;
      end else begin
        // descending position counts as no gap
        gap = (pos > prev_hit_pos[idx]) ? 33'(pos) - 33'(prev_hit_pos[idx]) : '0;
        prev_hit_pos[idx] = pos;
        add_to_sum(idx, reduced_step(gap, freq));
      end
    end else begin
      due.occurred = id_seen[idx];
      if (id_seen[idx]) begin
        // cyclic interval from the last hit around to the first one
        wrap_end = 33'(first_pos[idx]) + 33'(corpus_size);
        gap = (wrap_end > 33'(prev_hit_pos[idx])) ? wrap_end - 33'(prev_hit_pos[idx]) : '0;
        add_to_sum(idx, reduced_step(gap, freq));
      end
      due.id    = idx[arfe_pkg::IN_ID_W-1:0];
      due.value = arf_sum[idx];
      due_readouts.push_back(due);
      id_seen[idx]      = 1'b0;
      first_pos[idx]    = '0;
      prev_hit_pos[idx] = '0;
      arf_sum[idx]      = '0;
    end
  endfunction

  task automatic check_readout();
    readout_t due;
    if (due_readouts.size() == 0) begin
      flag_mismatch($sformatf("result for id %0d with no read-out pending", result_id_i));
      return;
    end
    due = due_readouts.pop_front();
    if (result_id_i !== due.id)
      flag_mismatch($sformatf("result_id %0d, expected %0d", result_id_i, due.id));
    if (occurred_i !== due.occurred)
      flag_mismatch($sformatf("id %0d occurred %b, expected %b", due.id, occurred_i,
                              due.occurred));
    if (arf_value_i !== due.value)
      flag_mismatch($sformatf("id %0d arf_value 'h%0h, expected 'h%0h", due.id, arf_value_i,
                              due.value));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corpus_size = arfe_pkg::CORPUS_RESET;
      for (int i = 0; i < ID_COUNT; i++) begin
        id_seen[i]      = 1'b0;
        first_pos[i]    = '0;
        prev_hit_pos[i] = '0;
        arf_sum[i]      = '0;
      end
      due_readouts.delete();
      outstanding_o <= 0;
    end else begin
      if (result_strobe_i) check_readout();
      if (cfg_we_i) corpus_size = cfg_wdata_i;
      if (start_i && !busy_i) apply_command(command_i, position_i, token_id_i, token_freq_i);
      outstanding_o <= due_readouts.size();
    end
  end

endmodule

FILE: tb/tb_average_reduced_frequency_engine_top.sv
// Testbench top for the ARF engine: clock, reset, command stimulus and the verdict.
`timescale 1ns / 100ps

module tb_average_reduced_frequency_engine_top;

  localparam int unsigned ID_BITS    = 16;
  localparam int unsigned POS_BITS   = 32;
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned SUM_W      = arfe_pkg::INT_BITS + FRAC_BITS;
  localparam int unsigned SETTLE_CYC = FRAC_BITS + 16;
  localparam longint      TIMEOUT_NS = 64'd2_000_000 * 12;
  localparam int unsigned PHASE_LEN  = 240;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [arfe_pkg::SIZE_W-1:0]   cfg_wdata_i;
  logic                          start_i;
  logic                          busy_o;
  logic                          command_i;
  logic [arfe_pkg::IN_POS_W-1:0] position_i;
  logic [arfe_pkg::IN_ID_W-1:0]  token_id_i;
  logic [arfe_pkg::FREQ_W-1:0]   token_freq_i;
  logic                          result_strobe_o;
  logic [arfe_pkg::IN_ID_W-1:0]  result_id_o;
  logic                          occurred_o;
  logic [SUM_W-1:0]              arf_value_o;

  int unsigned readouts_outstanding;
  int unsigned mismatch_total;
  int unsigned hit_count = 0;
  int unsigned read_count = 0;
  int unsigned size_writes = 0;

  average_reduced_frequency_engine_top #(
    .ID_BITS  (ID_BITS),
    .POS_BITS (POS_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .position_i     (position_i),
    .token_id_i     (token_id_i),
    .token_freq_i   (token_freq_i),
    .result_strobe_o(result_strobe_o),
    .result_id_o    (result_id_o),
    .occurred_o     (occurred_o),
    .arf_value_o    (arf_value_o)
  );

  arf_readout_monitor #(
    .ID_BITS  (ID_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) readout_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .command_i      (command_i),
    .position_i     (position_i),
    .token_id_i     (token_id_i),
    .token_freq_i   (token_freq_i),
    .result_strobe_i(result_strobe_o),
    .result_id_i    (result_id_o),
    .occurred_i     (occurred_o),
    .arf_value_i    (arf_value_o),
    .outstanding_o  (readouts_outstanding),
    .mismatches_o   (mismatch_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Holds start_i high until the transfer; leaves it high for a back-to-back command.
  task automatic send_command(input logic cmd, input logic [31:0] pos,
                              input logic [15:0] id, input logic [31:0] freq);
    start_i      <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    token_id_i   <= id;
    token_freq_i <= freq;
    do @(posedge clk_i); while (busy_o);
    if (cmd == arfe_pkg::CMD_HIT) hit_count++;
    else read_count++;
  endtask

  // Stop sending until every read-out has come back and the engine is idle.
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (readouts_outstanding != 0 || busy_o);
  endtask

  task automatic write_corpus_size(input logic [31:0] value);
    settle();
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_writes++;
  endtask

  task automatic run_directed();
    write_corpus_size(32'd1000);
    send_command(arfe_pkg::CMD_READ, 32'd0, 16'd0, 32'd1);       // never-seen id
    send_command(arfe_pkg::CMD_HIT, 32'd100, 16'd5, 32'd3);      // first hit
    send_command(arfe_pkg::CMD_HIT, 32'd200, 16'd5, 32'd3);      // fractional step
    send_command(arfe_pkg::CMD_HIT, 32'd200, 16'd5, 32'd3);      // same position
    send_command(arfe_pkg::CMD_HIT, 32'd150, 16'd5, 32'd3);      // position goes back
    send_command(arfe_pkg::CMD_HIT, 32'd160, 16'd5, 32'd0);      // zero frequency
    send_command(arfe_pkg::CMD_HIT, 32'd2000, 16'd5, 32'd3);     // gap beyond corpus
    send_command(arfe_pkg::CMD_HIT, 32'd2100, 16'd5, 32'd20);    // product reaches corpus
    send_command(arfe_pkg::CMD_READ, 32'd0, 16'd5, 32'd3);       // cyclic interval negative
    send_command(arfe_pkg::CMD_READ, 32'hFFFF_FFFF, 16'd5, 32'd3); // entry was cleared
    send_command(arfe_pkg::CMD_HIT, 32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(arfe_pkg::CMD_READ, 32'd0, 16'hFFFF, 32'd1);
    send_command(arfe_pkg::CMD_HIT, 32'd0, 16'd7, 32'd1);
    send_command(arfe_pkg::CMD_HIT, 32'hFFFF_FFFF, 16'd7, 32'd1);
    send_command(arfe_pkg::CMD_READ, 32'd0, 16'd7, 32'hFFFF_FFFF);
    // zero corpus size: every nonzero-frequency step is a full 1.0
    write_corpus_size(32'd0);
    send_command(arfe_pkg::CMD_HIT, 32'd10, 16'd3, 32'd1);
    send_command(arfe_pkg::CMD_HIT, 32'd11, 16'd3, 32'd1);
    send_command(arfe_pkg::CMD_READ, 32'd0, 16'd3, 32'd1);
    write_corpus_size(32'hFFFF_FFFF);
    send_command(arfe_pkg::CMD_HIT, 32'd1, 16'd9, 32'd1);
    send_command(arfe_pkg::CMD_HIT, 32'd5, 16'd9, 32'd7);
    send_command(arfe_pkg::CMD_READ, 32'd0, 16'd9, 32'd2);
  endtask

  // Mostly ascending hits on a small id pool with read-outs mixed in, plus some noise.
  task automatic random_phase(input logic [31:0] size, input int unsigned count,
                              input bit may_idle);
    logic [15:0] pool [6];
    logic [31:0] cursor;
    logic [31:0] span;
    logic [31:0] freq;
    logic [15:0] id;
    bit          idling;
    int unsigned pick;
    int unsigned roll;
    write_corpus_size(size);
    for (int k = 0; k < 6; k++) pool[k] = (k < 3) ? 16'($urandom_range(0, 15)) : 16'($urandom());
    cursor = $urandom_range(0, 1000);
    span   = (size < 64) ? 32'd64 : size / 16;
    idling = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) idling = may_idle && ($urandom_range(0, 2) != 0);
      if (may_idle && $urandom_range(0, 99) == 0) begin
        settle();
      end else if (idling && $urandom_range(0, 5) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      roll = $urandom_range(0, 19);
      freq = (roll == 0) ? 32'd0 : (roll < 3) ? 32'($urandom()) : 32'($urandom_range(1, 8));
      id   = pool[$urandom_range(0, 5)];
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_command(arfe_pkg::CMD_HIT, $urandom(),
                     ($urandom_range(0, 1) != 0) ? id : 16'($urandom()), freq);
      end else if (pick < 23) begin
        send_command(arfe_pkg::CMD_READ, $urandom(), (pick < 21) ? id : 16'($urandom()), freq);
      end else begin
        cursor += $urandom_range(0, span);
        send_command(arfe_pkg::CMD_HIT, cursor, id, freq);
      end
    end
  endtask

  initial begin
    int unsigned guard;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    start_i      <= 1'b0;
    command_i    <= arfe_pkg::CMD_HIT;
    position_i   <= '0;
    token_id_i   <= '0;
    token_freq_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    random_phase(32'hFFFF_FFFF, PHASE_LEN, 1'b1);
    random_phase(32'($urandom_range(2, 5000)), PHASE_LEN, 1'b1);
    random_phase(32'd1, PHASE_LEN, 1'b1);
    random_phase(32'd0, PHASE_LEN, 1'b1);
    random_phase(32'($urandom_range(32'h0010_0000, 32'h8000_0000)), PHASE_LEN, 1'b1);
    random_phase(32'd1000, PHASE_LEN, 1'b1);
    random_phase(32'd100000, PHASE_LEN, 1'b0);   // closing stretch runs without gaps

    start_i <= 1'b0;
    guard = 0;
    while ((readouts_outstanding != 0 || busy_o) && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Coverage: %0d hits, %0d read-outs, %0d corpus size writes", hit_count,
             read_count, size_writes);
    $display("Corpus sizes 0, 1, 2^32-1 and random values; gap, wrap and zero-freq cases hit");
    if (readouts_outstanding != 0)
      $display("%0d read-out results never arrived", readouts_outstanding);
    if (mismatch_total == 0 && readouts_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: engine stopped taking commands or returning results");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/arfe_pkg.sv
hdl/arfe_ram.sv
hdl/arfe_ctrl.sv
hdl/arfe_datapath.sv
hdl/average_reduced_frequency_engine_top.sv
tb/arf_readout_monitor.sv
tb/tb_average_reduced_frequency_engine_top.sv
